// ===== sv/utf8d_pkg.sv =====
// Package for the UTF-8 stream decoder.
// Result item type, lead-byte decode function and sizing constants; no dependencies.
package utf8d_pkg;

    localparam int CP_W       = 21;
    localparam int LEN_W      = 3;
    localparam int REM_W      = 2;
    localparam int FIFO_DEPTH = 8;

    localparam logic [LEN_W-1:0] LEN_NONE = 3'd0;
    localparam logic [LEN_W-1:0] LEN_ONE  = 3'd1;
    localparam logic [LEN_W-1:0] LEN_TWO  = 3'd2;
    localparam logic [LEN_W-1:0] LEN_THREE = 3'd3;
    localparam logic [LEN_W-1:0] LEN_FOUR = 3'd4;

    typedef struct packed {
        logic [CP_W-1:0]  code_point;
        logic [LEN_W-1:0] seq_length;
        logic             is_error;
        logic             last_of_run;
    } result_t;

    typedef struct packed {
        logic             hit;
        result_t          res;
        logic [CP_W-1:0]  pv;
        logic [REM_W-1:0] rem;
        logic [LEN_W-1:0] tot;
    } lead_t;

    localparam result_t ERR_RES = '{code_point: '0, seq_length: LEN_NONE,
                                    is_error: 1'b1, last_of_run: 1'b0};

    function automatic lead_t lead_decode(input logic [7:0] b);
        lead_t l;
        l = '0;
        if (b[7] == 1'b0) begin
            l.hit = 1'b1;
            l.res = '{code_point: CP_W'(b), seq_length: LEN_ONE,
                      is_error: 1'b0, last_of_run: 1'b0};
        end
        else if (b[7:5] == 3'b110) begin
            if (b[4:1] == 4'b0000) begin
                l.hit = 1'b1;
                l.res = ERR_RES;
            end
            else begin
                l.pv  = CP_W'(b[4:0]);
                l.rem = 2'd1;
                l.tot = LEN_TWO;
            end
        end
        else if (b[7:4] == 4'b1110) begin
            l.pv  = CP_W'(b[3:0]);
            l.rem = 2'd2;
            l.tot = LEN_THREE;
        end
        else if (b[7:3] == 5'b11110) begin
            l.pv  = CP_W'(b[2:0]);
            l.rem = 2'd3;
            l.tot = LEN_FOUR;
        end
        else begin
            l.hit = 1'b1;
            l.res = ERR_RES;
        end
        return l;
    endfunction

endpackage

// ===== sv/utf8_stream_decoder.sv =====
// Top level of the UTF-8 stream decoder: input register, decode stage, result queue.
// Depends on utf8d_pkg, utf8d_decode, utf8d_fifo.
//
//  channel | signals                                              | direction
//  --------+------------------------------------------------------+----------
//  input   | in_valid, in_ready, byte_in                          | in
//  output  | out_valid, out_ready, code_point, seq_length,        | out
//          | is_error, last_of_run                                |
//
// One byte per cycle while in_ready is high; a byte is decoded the cycle after
// acceptance; its results queue up and leave one per cycle while out_ready is high.
// A byte can yield two results; the result queue (FIFO_DEPTH entries) absorbs them.
// in_ready drops while the queue holds more than FIFO_DEPTH-4 results.
// rst_n clears the sequence state and empties the queue.
module utf8_stream_decoder
    import utf8d_pkg::*;
#(
    parameter int FIFO_DEPTH_P = FIFO_DEPTH
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [7:0]        byte_in,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [CP_W-1:0]   code_point,
    output logic [LEN_W-1:0]  seq_length,
    output logic              is_error,
    output logic              last_of_run
);

    localparam int CNT_W = $clog2(FIFO_DEPTH_P+1);

    logic              s1_valid_reg;
    logic [7:0]        s1_byte_reg;
    logic [1:0]        push_cnt;
    result_t           res0, res1, head;
    logic [CNT_W-1:0]  q_count;
    logic              in_acc;

    assign in_ready = (q_count <= CNT_W'(FIFO_DEPTH_P - 4));
    assign in_acc   = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            s1_valid_reg <= 1'b0;
        end
        else begin
            s1_valid_reg <= in_acc;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc) begin
            s1_byte_reg <= byte_in;
        end
    end

    utf8d_decode u_decode (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (s1_valid_reg),
        .byte_data  (s1_byte_reg),
        .push_cnt   (push_cnt),
        .res0       (res0),
        .res1       (res1)
    );

    utf8d_fifo #(
        .DEPTH (FIFO_DEPTH_P)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_cnt  (push_cnt),
        .wr0       (res0),
        .wr1       (res1),
        .pop       (out_ready),
        .head      (head),
        .not_empty (out_valid),
        .count     (q_count)
    );

    assign code_point  = head.code_point;
    assign seq_length  = head.seq_length;
    assign is_error    = head.is_error;
    assign last_of_run = head.last_of_run;

endmodule

// ===== sv/utf8d_decode.sv =====
// Sequence state and per-byte decode: turns one registered byte into up to two results.
// Depends on utf8d_pkg.
module utf8d_decode
    import utf8d_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       byte_valid,
    input  logic [7:0] byte_data,
    output logic [1:0] push_cnt,
    output result_t    res0,
    output result_t    res1
);

    logic [CP_W-1:0]  pv_reg,  pv_next;
    logic [REM_W-1:0] rem_reg, rem_next;
    logic [LEN_W-1:0] tot_reg, tot_next;
    logic [CP_W-1:0]  pv_shift;
    lead_t            lead;

    always_comb
    begin
        pv_shift = {pv_reg[CP_W-7:0], byte_data[5:0]};
        lead     = lead_decode(byte_data);
        pv_next  = pv_reg;
        rem_next = rem_reg;
        tot_next = tot_reg;
        push_cnt = 2'd0;
        res0     = ERR_RES;
        res1     = lead.res;
        res1.last_of_run = 1'b1;
        if (byte_valid) begin
            if (rem_reg != '0 && byte_data[7:6] == 2'b10) begin
                if (rem_reg == 2'd1) begin
                    push_cnt = 2'd1;
                    res0 = '{code_point: pv_shift, seq_length: tot_reg,
                             is_error: 1'b0, last_of_run: 1'b1};
                    pv_next  = '0;
                    rem_next = '0;
                    tot_next = LEN_NONE;
                end
                else begin
                    pv_next  = pv_shift;
                    rem_next = rem_reg - 2'd1;
                end
            end
            else begin
                pv_next  = lead.pv;
                rem_next = lead.rem;
                tot_next = lead.tot;
                if (rem_reg != '0) begin
                    // broken sequence: error first, then the byte as a lead
                    if (lead.hit) begin
                        push_cnt = 2'd2;
                    end
                    else begin
                        push_cnt = 2'd1;
                        res0.last_of_run = 1'b1;
                    end
                end
                else if (lead.hit) begin
                    push_cnt = 2'd1;
                    res0 = lead.res;
                    res0.last_of_run = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            pv_reg  <= '0;
            rem_reg <= '0;
            tot_reg <= LEN_NONE;
        end
        else begin
            pv_reg  <= pv_next;
            rem_reg <= rem_next;
            tot_reg <= tot_next;
        end
    end

endmodule

// ===== sv/utf8d_fifo.sv =====
// Result queue: takes up to two results a cycle, hands out one a cycle while pop is high.
// Depends on utf8d_pkg.
module utf8d_fifo
    import utf8d_pkg::*;
#(
    parameter int DEPTH = FIFO_DEPTH
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [1:0]                 push_cnt,
    input  result_t                    wr0,
    input  result_t                    wr1,
    input  logic                       pop,
    output result_t                    head,
    output logic                       not_empty,
    output logic [$clog2(DEPTH+1)-1:0] count
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH+1);

    result_t            mem [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   cnt_reg,    cnt_next;
    logic               do_pop;

    assign do_pop    = pop && (cnt_reg != '0);
    assign not_empty = (cnt_reg != '0);
    assign head      = mem[rd_ptr_reg];
    assign count     = cnt_reg;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + PTR_W'(push_cnt);
        rd_ptr_next = rd_ptr_reg + PTR_W'(do_pop);
        cnt_next    = cnt_reg + CNT_W'(push_cnt) - CNT_W'(do_pop);
    end

    always_ff @(posedge clk)
    begin
        if (push_cnt != 2'd0) begin
            mem[wr_ptr_reg] <= wr0;
        end
        if (push_cnt == 2'd2) begin
            mem[wr_ptr_reg + PTR_W'(1)] <= wr1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps
// Testbench for utf8_stream_decoder: byte items in, decoded characters out, each checked
// against a behavioral decoder kept inside this file. Depends on utf8d_pkg and the RTL.
module testbench;
    import utf8d_pkg::*;

    localparam int STALL_LIMIT     = 2000;
    localparam int HOLD_OFF_CYCLES = 80;

    typedef struct {
        logic [7:0]  data;
        int unsigned gap;
    } stream_byte_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              in_ready;
    logic [7:0]        byte_in = 8'h00;
    logic              out_valid;
    logic              out_ready = 1'b0;
    logic [CP_W-1:0]   code_point;
    logic [LEN_W-1:0]  seq_length;
    logic              is_error;
    logic              last_of_run;

    stream_byte_t      stream_bytes[$];
    result_t           expected_chars[$];

    logic [CP_W-1:0]   cp_accum = '0;
    logic [REM_W-1:0]  cont_left = '0;
    logic [LEN_W-1:0]  seq_total = LEN_NONE;

    logic              in_accepted = 1'b0;
    logic              out_accepted = 1'b0;
    stream_byte_t      next_byte;
    logic              have_next = 1'b0;
    int unsigned       wait_left = 0;
    int unsigned       stall_left = 0;
    int unsigned       hold_left = 0;
    int unsigned       sink_max_stall = 0;
    int                hold_trigger = 0;
    int                hold_seen = 0;
    int                idle_cycles = 0;
    int                mismatch_count = 0;
    result_t           want;

    logic [7:0] directed_bytes [27] = '{
        8'h00, 8'h7F, 8'hC2, 8'h80, 8'hDF, 8'hBF, 8'hC0, 8'hC1, 8'h80,
        8'hE0, 8'h80, 8'h80, 8'hEF, 8'hBF, 8'hBF, 8'hF7, 8'hBF, 8'hBF,
        8'hBF, 8'hF0, 8'h90, 8'hFF, 8'hE2, 8'h41, 8'hE2, 8'hC3, 8'hA9
    };

    utf8_stream_decoder DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .byte_in     (byte_in),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .code_point  (code_point),
        .seq_length  (seq_length),
        .is_error    (is_error),
        .last_of_run (last_of_run)
    );

    always #5 clk = ~clk;

    function automatic result_t make_result(input logic [CP_W-1:0] cp,
                                            input logic [LEN_W-1:0] len,
                                            input logic err);
        result_t r;
        r.code_point  = cp;
        r.seq_length  = len;
        r.is_error    = err;
        r.last_of_run = 1'b0;
        return r;
    endfunction

    task automatic decode_byte(input logic [7:0] b);
        int      base;
        logic    done;
        result_t r;
        base = expected_chars.size();
        done = 1'b0;
        if (cont_left != '0)
        begin
            if (b[7:6] == 2'b10)
            begin
                cp_accum  = {cp_accum[CP_W-7:0], b[5:0]};
                cont_left = cont_left - 1'b1;
                if (cont_left == '0)
                begin
                    expected_chars.push_back(make_result(cp_accum, seq_total, 1'b0));
                    cp_accum  = '0;
                    seq_total = LEN_NONE;
                end
                done = 1'b1;
            end
            else
            begin
                // broken sequence: drop it, then treat the byte as a lead
                expected_chars.push_back(make_result('0, LEN_NONE, 1'b1));
                cp_accum  = '0;
                cont_left = '0;
                seq_total = LEN_NONE;
            end
        end
        if (!done)
        begin
            if (b[7] == 1'b0)
                expected_chars.push_back(make_result(CP_W'(b), LEN_ONE, 1'b0));
            else if (b[7:5] == 3'b110 && b[4:0] < 5'd2)
                expected_chars.push_back(make_result('0, LEN_NONE, 1'b1));
            else if (b[7:5] == 3'b110)
            begin
                cp_accum  = CP_W'(b[4:0]);
                cont_left = 2'd1;
                seq_total = LEN_TWO;
            end
            else if (b[7:4] == 4'b1110)
            begin
                cp_accum  = CP_W'(b[3:0]);
                cont_left = 2'd2;
                seq_total = LEN_THREE;
            end
            else if (b[7:3] == 5'b11110)
            begin
                cp_accum  = CP_W'(b[2:0]);
                cont_left = 2'd3;
                seq_total = LEN_FOUR;
            end
            else
                expected_chars.push_back(make_result('0, LEN_NONE, 1'b1));
        end
        if (expected_chars.size() > base)
        begin
            r = expected_chars.pop_back();
            r.last_of_run = 1'b1;
            expected_chars.push_back(r);
        end
    endtask

    task automatic report_mismatch(input string what);
        mismatch_count++;
        $display("ERROR at %0t: %s", $realtime, what);
    endtask

    task automatic queue_byte(input logic [7:0] b, input int unsigned max_gap);
        stream_byte_t s;
        s.data = b;
        s.gap  = $urandom_range(0, max_gap);
        stream_bytes.push_back(s);
    endtask

    // mostly well-formed sequences, some noise bytes and truncated sequences
    task automatic queue_random_text(input int n_bytes, input int unsigned max_gap);
        int         added;
        int         kind;
        int         len;
        int         cut;
        int         k;
        logic [7:0] b;
        added = 0;
        while (added < n_bytes)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 15)
            begin
                queue_byte(8'($urandom_range(0, 255)), max_gap);
                added++;
            end
            else
            begin
                len = $urandom_range(1, 4);
                case (len)
                    1: b = 8'($urandom_range(0, 127));
                    2: b = 8'hC0 | 8'($urandom_range(2, 31));
                    3: b = 8'hE0 | 8'($urandom_range(0, 15));
                    default: b = 8'hF0 | 8'($urandom_range(0, 7));
                endcase
                queue_byte(b, max_gap);
                added++;
                cut = (kind < 27 && len > 1) ? $urandom_range(1, len - 1) : len;
                for (k = 1; k < len; k++)
                begin
                    if (k == cut)
                    begin
                        b = 8'($urandom_range(0, 255));
                        if (b[7:6] == 2'b10)
                            b = b ^ 8'h40;
                        queue_byte(b, max_gap);
                        added++;
                        break;
                    end
                    queue_byte(8'h80 | 8'($urandom_range(0, 63)), max_gap);
                    added++;
                end
            end
        end
    endtask

    task automatic wait_drained;
        while (stream_bytes.size() != 0 || have_next || in_valid || expected_chars.size() != 0)
            @(posedge clk);
    endtask

    // sender
    always @(negedge clk)
    begin
        if (rst_n && !(in_valid && !in_accepted))
        begin
            if (!have_next && stream_bytes.size() != 0)
            begin
                next_byte = stream_bytes.pop_front();
                wait_left = next_byte.gap;
                have_next = 1'b1;
            end
            if (have_next && wait_left == 0)
            begin
                in_valid  <= 1'b1;
                byte_in   <= next_byte.data;
                have_next = 1'b0;
            end
            else
            begin
                in_valid <= 1'b0;
                if (have_next)
                    wait_left--;
            end
        end
    end

    // receiver
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (hold_seen != hold_trigger)
            begin
                hold_seen = hold_trigger;
                hold_left = HOLD_OFF_CYCLES;
            end
            if (out_accepted)
                stall_left = $urandom_range(0, sink_max_stall);
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // monitor, checker and watchdog
    always @(posedge clk)
    begin
        in_accepted  <= in_valid && in_ready;
        out_accepted <= out_valid && out_ready;
        if (rst_n && in_valid && in_ready)
            decode_byte(byte_in);
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_chars.size() == 0)
                report_mismatch($sformatf("unexpected item cp=%h len=%0d err=%b last=%b",
                                          code_point, seq_length, is_error, last_of_run));
            else
            begin
                want = expected_chars.pop_front();
                if (code_point !== want.code_point || seq_length !== want.seq_length ||
                    is_error !== want.is_error || last_of_run !== want.last_of_run)
                    report_mismatch($sformatf(
                        "got cp=%h len=%0d err=%b last=%b, want cp=%h len=%0d err=%b last=%b",
                        code_point, seq_length, is_error, last_of_run, want.code_point,
                        want.seq_length, want.is_error, want.last_of_run));
            end
        end
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("Timeout: no item moved for %0d cycles", STALL_LIMIT);
            $display("Mismatches found");
            $finish;
        end
    end

    initial
    begin
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        sink_max_stall = 3;
        foreach (directed_bytes[i])
            queue_byte(directed_bytes[i], 3);
        wait_drained();

        sink_max_stall = 17;
        queue_random_text(300, 17);
        wait_drained();

        sink_max_stall = 0;
        queue_random_text(250, 0);
        wait_drained();

        // receiver stops while bytes keep coming back to back
        hold_trigger++;
        queue_random_text(60, 0);
        wait_drained();

        sink_max_stall = 17;
        queue_random_text(270, 5);
        wait_drained();

        repeat (20) @(posedge clk);
        while (expected_chars.size() != 0)
        begin
            want = expected_chars.pop_front();
            report_mismatch($sformatf("missing item cp=%h len=%0d err=%b last=%b",
                                      want.code_point, want.seq_length, want.is_error,
                                      want.last_of_run));
        end
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
